/* src/lpac_pkg.sv */
// Shared types and constants for the layer priority alpha compositor.
`default_nettype none

package lpac_pkg;

  // Field widths.
  localparam int COORD_W    = 8;
  localparam int PIX_W      = 16;
  localparam int COLOR_W    = 15;
  localparam int CH_W       = 5;
  localparam int FACTOR_W   = 5;
  localparam int PROD_W     = 2 * CH_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int NUM_BG     = 4;

  // Blend arithmetic constants.
  localparam logic [FACTOR_W-1:0] FACTOR_MAX = 5'd16;
  localparam logic [CH_W-1:0]     CH_MAX     = 5'h1F;
  localparam logic [COLOR_W-1:0]  COLOR_WHITE = 15'h7FFF;
  localparam logic [COLOR_W-1:0]  COLOR_BLACK = 15'h0000;

  // Layer codes as used by the bottom target bits.
  localparam logic [2:0] LAYER_OBJ = 3'd4;
  localparam logic [2:0] LAYER_BD  = 3'd5;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LAYER_ENABLES  = 3'd0,
    CFG_BLEND_CONTROL  = 3'd1,
    CFG_BLEND_FACTORS  = 3'd2,
    CFG_WINDOW0_BOUNDS = 3'd3,
    CFG_WINDOW1_BOUNDS = 3'd4,
    CFG_WIN_FX_ENABLES = 3'd5,
    CFG_BG_PRIORITY    = 3'd6,
    CFG_BACKDROP_COLOR = 3'd7
  } cfg_index_t;

  // Color effect modes, also used as the resolved operation of a pixel.
  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_ALPHA = 2'd1,
    MODE_WHITE = 2'd2,
    MODE_BLACK = 2'd3
  } blend_mode_t;

  // Running state of the layer walk: last drawn color and layer, and the
  // operands of the color that would be shown so far.
  typedef struct packed {
    logic [COLOR_W-1:0] last;
    logic [2:0]         last_layer;
    logic [COLOR_W-1:0] upper;
    logic [COLOR_W-1:0] lower;
    blend_mode_t        op;
  } comp_state_t;

endpackage

`default_nettype wire

/* src/lpac_if.sv */
// Valid/ready channel interfaces for compositor pixel and color beats.
`default_nettype none

interface lpac_in_if;
  import lpac_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] pixel_x;
  logic [COORD_W-1:0] line_y;
  logic [PIX_W-1:0]   bg0_pixel;
  logic [PIX_W-1:0]   bg1_pixel;
  logic [PIX_W-1:0]   bg2_pixel;
  logic [PIX_W-1:0]   bg3_pixel;
  logic [PIX_W-1:0]   sprite_pixel;
  logic [1:0]         sprite_priority;
  logic               sprite_semi_transparent;
  logic               in_object_window;

  modport source (
    output valid, pixel_x, line_y, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel,
           sprite_pixel, sprite_priority, sprite_semi_transparent, in_object_window,
    input  ready
  );

  modport sink (
    input  valid, pixel_x, line_y, bg0_pixel, bg1_pixel, bg2_pixel, bg3_pixel,
           sprite_pixel, sprite_priority, sprite_semi_transparent, in_object_window,
    output ready
  );
endinterface

interface lpac_out_if;
  import lpac_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] final_color;

  modport source (output valid, final_color, input ready);
  modport sink (input valid, final_color, output ready);
endinterface

`default_nettype wire

/* src/layer_priority_alpha_compositor_top.sv */
// Top level of the layer priority alpha compositor pipeline.
//
// Usage: each input beat on in_ch carries one screen pixel: its coordinates,
// four background pixels and one sprite pixel (bit 15 marks transparency),
// the sprite priority, semi-transparency and object window flags. Each beat
// yields exactly one beat on out_ch with the composited 15-bit color.
// Registers are written through cfg_we/cfg_index/cfg_data while no pixel is
// in flight; a write takes effect at the clock edge where cfg_we is high.
// Stages from input beat to output beat: decode and windows, two layer-walk
// stages of two priority slots each, one stage of channel multiplies, and
// the sum/saturate output register. Throughput is one pixel per cycle while
// out_ch.ready stays high; the per-stage valid bits and the ready chain set
// that figure. When out_ch.ready is low, stages fill up behind the output
// register and in_ch.ready drops only once every stage holds a pixel; nothing
// is lost or repeated. Synchronous reset clears the configuration registers to
// zero and clears every stage valid bit, which empties the pipeline.
`default_nettype none

module layer_priority_alpha_compositor_top (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  lpac_in_if.sink                              in_ch,
  lpac_out_if.source                           out_ch,
  input  wire logic                            cfg_we,
  input  wire logic [lpac_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lpac_pkg::CFG_DATA_W-1:0] cfg_data
);
  import lpac_pkg::*;

  // Configuration registers.
  logic [6:0]         layer_enables_r;
  logic [13:0]        blend_control_r;
  logic [14:0]        blend_factors_r;
  logic [31:0]        window0_bounds_r;
  logic [31:0]        window1_bounds_r;
  logic [3:0]         win_fx_enables_r;
  logic [7:0]         bg_priority_r;
  logic [COLOR_W-1:0] backdrop_color_r;

  // Pipeline registers.
  logic               s1_v_r, s2_v_r, s3_v_r, s4_v_r, out_v_r;
  logic               s1_adv, s2_adv, s3_adv, s4_adv, out_adv;

  logic [1:0]         s1_id_r [NUM_BG];
  logic [PIX_W-1:0]   s1_pix_r [NUM_BG];
  logic [PIX_W-1:0]   s1_spr_r;
  logic [1:0]         s1_spr_prio_r;
  logic               s1_spr_alpha_r;
  logic               s1_win_fx_r;

  comp_state_t        s2_st_r;
  logic [1:0]         s2_id_r [2];
  logic [PIX_W-1:0]   s2_pix_r [2];
  logic [PIX_W-1:0]   s2_spr_r;
  logic [1:0]         s2_spr_prio_r;
  logic               s2_spr_alpha_r;
  logic               s2_win_fx_r;

  logic [COLOR_W-1:0]  s3_lower_r, s3_upper_r;
  logic [FACTOR_W-1:0] s3_fl_r, s3_fu_r;

  logic [PROD_W-1:0]  s4_lo_r [3];
  logic [PROD_W-1:0]  s4_up_r [3];

  logic [COLOR_W-1:0] out_color_r;

  // Combinational signals.
  logic [PIX_W-1:0]   bg_pix [NUM_BG];
  logic [1:0]         prio [NUM_BG];
  logic [1:0]         rank [NUM_BG];
  logic [1:0]         slot_id [NUM_BG];
  logic               w0_in, w1_in, w0_disp, w1_disp, obj_disp;
  logic               win_fx;
  comp_state_t        st_init, st_a, st_b, st_c, st_d;
  logic [FACTOR_W-1:0] ea, eb, ey;
  logic [COLOR_W-1:0]  lower_sel, upper_sel;
  logic [FACTOR_W-1:0] fl_sel, fu_sel;
  logic [COLOR_W-1:0]  color_nxt;

  // Inclusive rectangle test; an inverted rectangle contains nothing.
  function automatic logic win_inside(logic [31:0] bounds, logic [COORD_W-1:0] x,
                                      logic [COORD_W-1:0] y);
    return (x >= bounds[7:0]) && (x <= bounds[15:8]) &&
           (y >= bounds[23:16]) && (y <= bounds[31:24]);
  endfunction

  function automatic logic [FACTOR_W-1:0] clamp16(logic [FACTOR_W-1:0] f);
    return (f >= FACTOR_MAX) ? FACTOR_MAX : f;
  endfunction

  // One priority slot of the layer walk: its background, then the sprite if
  // the sprite priority matches the slot.
  function automatic comp_state_t slot_step(
    comp_state_t st, logic [1:0] slot, logic [1:0] bg, logic [PIX_W-1:0] pix,
    logic [PIX_W-1:0] spr, logic [1:0] spr_prio, logic spr_alpha, logic wfx,
    logic [6:0] le, logic [13:0] bc);
    comp_state_t nx;
    blend_mode_t mode;
    logic [5:0]  bottom;
    logic [3:0]  bg_en, top_tgt;
    logic        below, top, single, do_blend, obj_blend, drawn;
    nx        = st;
    mode      = blend_mode_t'(bc[13:12]);
    bottom    = bc[11:6];
    bg_en     = le[3:0];
    top_tgt   = bc[3:0];
    below     = bottom[st.last_layer];
    top       = top_tgt[bg];
    single    = (mode == MODE_WHITE) || (mode == MODE_BLACK);
    do_blend  = wfx && top && (((mode == MODE_ALPHA) && below) || single);
    obj_blend = spr_alpha && (below || single);
    drawn     = bg_en[bg] && !pix[PIX_W-1];
    if (drawn) begin
      nx.upper      = pix[COLOR_W-1:0];
      nx.lower      = st.last;
      nx.op         = do_blend ? mode : MODE_OFF;
      nx.last       = pix[COLOR_W-1:0];
      nx.last_layer = {1'b0, bg};
    end
    // The sprite test uses the layer beneath at the start of the slot.
    if ((spr_prio == slot) && !spr[PIX_W-1]) begin
      nx.upper      = spr[COLOR_W-1:0];
      nx.lower      = nx.last;
      nx.op         = obj_blend ? (below ? MODE_ALPHA : mode) : MODE_OFF;
      nx.last       = spr[COLOR_W-1:0];
      nx.last_layer = LAYER_OBJ;
    end
    return nx;
  endfunction

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      layer_enables_r  <= '0;
      blend_control_r  <= '0;
      blend_factors_r  <= '0;
      window0_bounds_r <= '0;
      window1_bounds_r <= '0;
      win_fx_enables_r <= '0;
      bg_priority_r    <= '0;
      backdrop_color_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_LAYER_ENABLES:  layer_enables_r  <= cfg_data[6:0];
        CFG_BLEND_CONTROL:  blend_control_r  <= cfg_data[13:0];
        CFG_BLEND_FACTORS:  blend_factors_r  <= cfg_data[14:0];
        CFG_WINDOW0_BOUNDS: window0_bounds_r <= cfg_data;
        CFG_WINDOW1_BOUNDS: window1_bounds_r <= cfg_data;
        CFG_WIN_FX_ENABLES: win_fx_enables_r <= cfg_data[3:0];
        CFG_BG_PRIORITY:    bg_priority_r    <= cfg_data[7:0];
        CFG_BACKDROP_COLOR: backdrop_color_r <= cfg_data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Ready chain: a stage moves when it is empty or its successor moves.
  assign out_adv     = !out_v_r || out_ch.ready;
  assign s4_adv      = !s4_v_r || out_adv;
  assign s3_adv      = !s3_v_r || s4_adv;
  assign s2_adv      = !s2_v_r || s3_adv;
  assign s1_adv      = !s1_v_r || s2_adv;
  assign in_ch.ready = s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      s4_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv)  s1_v_r  <= in_ch.valid;
      if (s2_adv)  s2_v_r  <= s1_v_r;
      if (s3_adv)  s3_v_r  <= s2_v_r;
      if (s4_adv)  s4_v_r  <= s3_v_r;
      if (out_adv) out_v_r <= s4_v_r;
    end
  end

  // Stage 1: stable priority sort of the backgrounds and window selection.
  assign bg_pix[0] = in_ch.bg0_pixel;
  assign bg_pix[1] = in_ch.bg1_pixel;
  assign bg_pix[2] = in_ch.bg2_pixel;
  assign bg_pix[3] = in_ch.bg3_pixel;

  always_comb begin
    for (int b = 0; b < NUM_BG; b++) begin
      prio[b] = bg_priority_r[2*b +: 2];
    end
    for (int b = 0; b < NUM_BG; b++) begin
      rank[b] = 2'd0;
      for (int j = 0; j < NUM_BG; j++) begin
        if ((prio[j] < prio[b]) || ((prio[j] == prio[b]) && (j < b))) begin
          rank[b] = rank[b] + 2'd1;
        end
      end
    end
    for (int s = 0; s < NUM_BG; s++) begin
      slot_id[s] = 2'd0;
      for (int b = 0; b < NUM_BG; b++) begin
        if (rank[b] == 2'(s)) slot_id[s] = 2'(b);
      end
    end
  end

  always_comb begin
    w0_in    = win_inside(window0_bounds_r, in_ch.pixel_x, in_ch.line_y);
    w1_in    = win_inside(window1_bounds_r, in_ch.pixel_x, in_ch.line_y);
    w0_disp  = layer_enables_r[4];
    w1_disp  = layer_enables_r[5];
    obj_disp = layer_enables_r[6];
    win_fx   = 1'b1;
    if (w0_in && w0_disp) begin
      win_fx = win_fx_enables_r[0];
    end else if (w1_in && w1_disp) begin
      win_fx = win_fx_enables_r[1];
    end else if (in_ch.in_object_window && obj_disp) begin
      win_fx = win_fx_enables_r[2];
    end else if (!(w0_in || w1_in) && (w0_disp || w1_disp)) begin
      win_fx = win_fx_enables_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int s = 0; s < NUM_BG; s++) begin
        s1_id_r[s]  <= slot_id[s];
        s1_pix_r[s] <= bg_pix[slot_id[s]];
      end
      s1_spr_r       <= in_ch.sprite_pixel;
      s1_spr_prio_r  <= in_ch.sprite_priority;
      s1_spr_alpha_r <= in_ch.sprite_semi_transparent;
      s1_win_fx_r    <= win_fx;
    end
  end

  // Stage 2: walk slots 3 and 2 on top of the backdrop.
  always_comb begin
    st_init.last       = backdrop_color_r;
    st_init.last_layer = LAYER_BD;
    st_init.upper      = backdrop_color_r;
    st_init.lower      = COLOR_BLACK;
    st_init.op         = MODE_OFF;
    st_a = slot_step(st_init, 2'd3, s1_id_r[3], s1_pix_r[3], s1_spr_r, s1_spr_prio_r,
                     s1_spr_alpha_r, s1_win_fx_r, layer_enables_r, blend_control_r);
    st_b = slot_step(st_a, 2'd2, s1_id_r[2], s1_pix_r[2], s1_spr_r, s1_spr_prio_r,
                     s1_spr_alpha_r, s1_win_fx_r, layer_enables_r, blend_control_r);
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_st_r        <= st_b;
      s2_id_r[0]     <= s1_id_r[0];
      s2_id_r[1]     <= s1_id_r[1];
      s2_pix_r[0]    <= s1_pix_r[0];
      s2_pix_r[1]    <= s1_pix_r[1];
      s2_spr_r       <= s1_spr_r;
      s2_spr_prio_r  <= s1_spr_prio_r;
      s2_spr_alpha_r <= s1_spr_alpha_r;
      s2_win_fx_r    <= s1_win_fx_r;
    end
  end

  // Stage 3: walk slots 1 and 0, then pick mix operands and factors.
  always_comb begin
    st_c = slot_step(s2_st_r, 2'd1, s2_id_r[1], s2_pix_r[1], s2_spr_r, s2_spr_prio_r,
                     s2_spr_alpha_r, s2_win_fx_r, layer_enables_r, blend_control_r);
    st_d = slot_step(st_c, 2'd0, s2_id_r[0], s2_pix_r[0], s2_spr_r, s2_spr_prio_r,
                     s2_spr_alpha_r, s2_win_fx_r, layer_enables_r, blend_control_r);
    ea = clamp16(blend_factors_r[4:0]);
    eb = clamp16(blend_factors_r[9:5]);
    ey = clamp16(blend_factors_r[14:10]);
    upper_sel = st_d.upper;
    // No effect is a mix with unit weight on the upper color.
    case (st_d.op)
      MODE_ALPHA: begin
        lower_sel = st_d.lower;
        fl_sel    = eb;
        fu_sel    = ea;
      end
      MODE_WHITE: begin
        lower_sel = COLOR_WHITE;
        fl_sel    = ey;
        fu_sel    = FACTOR_MAX - ey;
      end
      MODE_BLACK: begin
        lower_sel = COLOR_BLACK;
        fl_sel    = ey;
        fu_sel    = FACTOR_MAX - ey;
      end
      default: begin
        lower_sel = COLOR_BLACK;
        fl_sel    = '0;
        fu_sel    = FACTOR_MAX;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      s3_lower_r <= lower_sel;
      s3_upper_r <= upper_sel;
      s3_fl_r    <= fl_sel;
      s3_fu_r    <= fu_sel;
    end
  end

  // Stage 4: per-channel weight multiplies.
  always_ff @(posedge clk) begin
    if (s4_adv) begin
      for (int c = 0; c < 3; c++) begin
        s4_lo_r[c] <= {{(PROD_W-CH_W){1'b0}}, s3_lower_r[c*CH_W +: CH_W]} *
                      {{(PROD_W-FACTOR_W){1'b0}}, s3_fl_r};
        s4_up_r[c] <= {{(PROD_W-CH_W){1'b0}}, s3_upper_r[c*CH_W +: CH_W]} *
                      {{(PROD_W-FACTOR_W){1'b0}}, s3_fu_r};
      end
    end
  end

  // Stage 5: sum, scale down by 16 and saturate each channel.
  always_comb begin
    logic [PROD_W:0]   sum;
    logic [PROD_W-4:0] scaled;
    color_nxt = '0;
    for (int c = 0; c < 3; c++) begin
      sum    = {1'b0, s4_lo_r[c]} + {1'b0, s4_up_r[c]};
      scaled = sum[PROD_W:4];
      color_nxt[c*CH_W +: CH_W] = (scaled > {2'b00, CH_MAX}) ? CH_MAX : scaled[CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_color_r <= color_nxt;
    end
  end

  assign out_ch.valid       = out_v_r;
  assign out_ch.final_color = out_color_r;

  // Input is held off only when every stage is full behind a stalled output.
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_v_r && !out_ch.ready && s1_v_r && s2_v_r && s3_v_r && s4_v_r))
    else $error("input held off while the pipeline has room");

  // An accepted beat always lands in the first stage.
  a_accept_loads_s1: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> s1_v_r)
    else $error("accepted beat did not enter stage 1");

  // Mix weights stay within the clamped range and sum to at most twice unity.
  a_factor_range: assert property (@(posedge clk) disable iff (!rst_n)
    s3_v_r |-> ((s3_fl_r <= FACTOR_MAX) && (s3_fu_r <= FACTOR_MAX)))
    else $error("blend factor above 16");

  // A new output beat only appears from a filled multiply stage.
  a_out_from_s4: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_v_r) |-> $past(s4_v_r))
    else $error("output valid without a pixel in the multiply stage");

endmodule

`default_nettype wire

/* test/testbench.sv */
// Self-checking testbench for the layer priority alpha compositor top level.
`timescale 1ns / 1ps

module testbench;
  import lpac_pkg::*;

  localparam int          NUM_PHASES     = 12;
  localparam int          PHASE_PIXELS   = 136;
  localparam int          DRAIN_CYCLES   = 12;
  localparam int          CYCLE_LIMIT    = 200000;
  localparam int          MAX_REPORTS    = 10;
  localparam int          TRANSPARENT    = 15;
  localparam int unsigned FULL_FACTOR    = 16;

  // One screen pixel as it travels on the input channel.
  typedef struct packed {
    logic [COORD_W-1:0]           pixel_x;
    logic [COORD_W-1:0]           line_y;
    logic [NUM_BG-1:0][PIX_W-1:0] bg_pixel;
    logic [PIX_W-1:0]             sprite_pixel;
    logic [1:0]                   sprite_priority;
    logic                         semi_transparent;
    logic                         object_window;
  } pixel_beat_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  lpac_in_if  in_ch ();
  lpac_out_if out_ch ();

  layer_priority_alpha_compositor_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow copies of the compositor registers.
  logic [6:0]         reg_layer_enables;
  logic [13:0]        reg_blend_control;
  logic [14:0]        reg_blend_factors;
  logic [31:0]        reg_window0;
  logic [31:0]        reg_window1;
  logic [3:0]         reg_win_fx;
  logic [7:0]         reg_bg_priority;
  logic [COLOR_W-1:0] reg_backdrop;

  pixel_beat_t        pending_pixels[$];
  logic [COLOR_W-1:0] expected_colors[$];
  pixel_beat_t        beat_on_wire;
  logic [COLOR_W-1:0] oldest_color;

  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned pixels_issued;
  int unsigned pixels_accepted;
  int unsigned results_seen;
  int unsigned mismatches;
  int unsigned settings_count;
  int unsigned cycle_count;

  // Free-running clock.
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic int unsigned clamp_factor(logic [FACTOR_W-1:0] f);
    return (f >= FACTOR_MAX) ? FULL_FACTOR : int'(f);
  endfunction

  // Weighted sum of two colors per channel, shifted down by four and saturated.
  function automatic logic [COLOR_W-1:0] mix_colors(logic [COLOR_W-1:0] lower, int unsigned fl,
                                                    logic [COLOR_W-1:0] upper, int unsigned fu);
    logic [COLOR_W-1:0] r;
    int unsigned        s;
    r = '0;
    for (int c = 0; c < 3; c++) begin
      s = (int'(lower[CH_W*c +: CH_W]) * fl + int'(upper[CH_W*c +: CH_W]) * fu) >> 4;
      if (s > int'(CH_MAX)) s = int'(CH_MAX);
      r[CH_W*c +: CH_W] = s[CH_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [COLOR_W-1:0] blend_effect(blend_mode_t mode,
                                                      logic [COLOR_W-1:0] lower,
                                                      logic [COLOR_W-1:0] upper);
    int unsigned ea;
    int unsigned eb;
    int unsigned ey;
    ea = clamp_factor(reg_blend_factors[4:0]);
    eb = clamp_factor(reg_blend_factors[9:5]);
    ey = clamp_factor(reg_blend_factors[14:10]);
    case (mode)
      MODE_ALPHA: return mix_colors(lower, eb, upper, ea);
      MODE_WHITE: return mix_colors(COLOR_WHITE, ey, upper, FULL_FACTOR - ey);
      default:    return mix_colors(COLOR_BLACK, ey, upper, FULL_FACTOR - ey);
    endcase
  endfunction

  function automatic logic window_contains(logic [31:0] bounds, logic [7:0] x, logic [7:0] y);
    return x >= bounds[7:0] && x <= bounds[15:8] && y >= bounds[23:16] && y <= bounds[31:24];
  endfunction

  // Color the compositor should produce for one pixel under the current registers.
  function automatic logic [COLOR_W-1:0] composite_pixel(pixel_beat_t pb);
    int unsigned        order [NUM_BG];
    int unsigned        n;
    int unsigned        bg;
    int                 i;
    blend_mode_t        mode;
    logic               single, w0, w1, w0d, w1d, wod, win_fx;
    logic               below, top, multi, do_blend, obj_blend, drawn;
    logic [PIX_W-1:0]   pix;
    logic [COLOR_W-1:0] last, draw;
    logic [2:0]         last_layer;
    n = 0;
    for (int p = 0; p < 4; p++) begin
      for (int b = 0; b < NUM_BG; b++) begin
        if (int'(reg_bg_priority[2*b +: 2]) == p) begin
          order[n] = b;
          n++;
        end
      end
    end
    mode   = blend_mode_t'(reg_blend_control[13:12]);
    single = (mode == MODE_WHITE) || (mode == MODE_BLACK);
    w0d    = reg_layer_enables[4];
    w1d    = reg_layer_enables[5];
    wod    = reg_layer_enables[6];
    w0     = window_contains(reg_window0, pb.pixel_x, pb.line_y);
    w1     = window_contains(reg_window1, pb.pixel_x, pb.line_y);

    // Window precedence: window0, window1, object window, then outside area.
    win_fx = 1'b1;
    if (w0 && w0d) begin
      win_fx = reg_win_fx[0];
    end else if (w1 && w1d) begin
      win_fx = reg_win_fx[1];
    end else if (pb.object_window && wod) begin
      win_fx = reg_win_fx[2];
    end else if (!(w0 || w1) && (w0d || w1d)) begin
      win_fx = reg_win_fx[3];
    end

    last       = reg_backdrop;
    draw       = reg_backdrop;
    last_layer = LAYER_BD;
    // Walk the priority slots from the back, sprite after its own slot.
    for (i = 3; i >= 0; i--) begin
      bg        = order[i];
      pix       = pb.bg_pixel[bg];
      below     = reg_blend_control[6 + int'(last_layer)];
      top       = reg_blend_control[bg];
      multi     = (mode == MODE_ALPHA) && below;
      do_blend  = win_fx && top && (multi || single);
      obj_blend = pb.semi_transparent && (below || single);
      drawn     = reg_layer_enables[bg] && !pix[TRANSPARENT];
      if (drawn) begin
        draw       = do_blend ? blend_effect(mode, last, pix[COLOR_W-1:0]) : pix[COLOR_W-1:0];
        last       = pix[COLOR_W-1:0];
        last_layer = bg[2:0];
      end
      if (int'(pb.sprite_priority) == i && !pb.sprite_pixel[TRANSPARENT]) begin
        if (obj_blend) begin
          draw = blend_effect(below ? MODE_ALPHA : mode, last, pb.sprite_pixel[COLOR_W-1:0]);
        end else begin
          draw = pb.sprite_pixel[COLOR_W-1:0];
        end
        last       = pb.sprite_pixel[COLOR_W-1:0];
        last_layer = LAYER_OBJ;
      end
    end
    return draw;
  endfunction

  function automatic pixel_beat_t directed_pixel(logic [7:0] x, logic [7:0] y,
                                                 logic [PIX_W-1:0] bg_word,
                                                 logic [PIX_W-1:0] spr, logic [1:0] prio,
                                                 logic semi, logic obj);
    pixel_beat_t pb;
    pb.pixel_x = x;
    pb.line_y  = y;
    // Give each background its own color while keeping the transparent bit.
    for (int b = 0; b < NUM_BG; b++) pb.bg_pixel[b] = bg_word ^ (16'(b) << 2);
    pb.sprite_pixel     = spr;
    pb.sprite_priority  = prio;
    pb.semi_transparent = semi;
    pb.object_window    = obj;
    return pb;
  endfunction

  function automatic logic [PIX_W-1:0] random_layer_pixel();
    logic [PIX_W-1:0] pix;
    pix = 16'($urandom);
    case ($urandom_range(19))
      0, 1:    pix[COLOR_W-1:0] = COLOR_WHITE;
      2:       pix[COLOR_W-1:0] = COLOR_BLACK;
      default: ;
    endcase
    pix[TRANSPARENT] = ($urandom_range(3) == 0);
    return pix;
  endfunction

  // Coordinate that often lands on or just beside a window edge.
  function automatic logic [7:0] coord_near(logic [7:0] lo, logic [7:0] hi);
    case ($urandom_range(7))
      0:       return lo;
      1:       return hi;
      2:       return lo - 8'd1;
      3:       return hi + 8'd1;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic pixel_beat_t random_pixel();
    pixel_beat_t pb;
    logic [31:0] win;
    win        = $urandom_range(1) ? reg_window1 : reg_window0;
    pb.pixel_x = coord_near(win[7:0], win[15:8]);
    pb.line_y  = coord_near(win[23:16], win[31:24]);
    for (int b = 0; b < NUM_BG; b++) pb.bg_pixel[b] = random_layer_pixel();
    pb.sprite_pixel     = random_layer_pixel();
    pb.sprite_priority  = 2'($urandom);
    pb.semi_transparent = 1'($urandom);
    pb.object_window    = 1'($urandom);
    return pb;
  endfunction

  function automatic logic [31:0] random_window();
    logic [7:0] x1, x2, y1, y2;
    x1 = 8'($urandom);
    x2 = 8'($urandom);
    y1 = 8'($urandom);
    y2 = 8'($urandom);
    // Mostly well-formed rectangles, sometimes empty ones.
    if ($urandom_range(4) != 0) begin
      if (x1 > x2) {x1, x2} = {x2, x1};
      if (y1 > y2) {y1, y2} = {y2, y1};
    end
    return {y2, y1, x2, x1};
  endfunction

  task automatic write_register(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    case (idx)
      CFG_LAYER_ENABLES:  reg_layer_enables = value[6:0];
      CFG_BLEND_CONTROL:  reg_blend_control = value[13:0];
      CFG_BLEND_FACTORS:  reg_blend_factors = value[14:0];
      CFG_WINDOW0_BOUNDS: reg_window0       = value;
      CFG_WINDOW1_BOUNDS: reg_window1       = value;
      CFG_WIN_FX_ENABLES: reg_win_fx        = value[3:0];
      CFG_BG_PRIORITY:    reg_bg_priority   = value[7:0];
      CFG_BACKDROP_COLOR: reg_backdrop      = value[14:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic write_all(logic [6:0] le, logic [13:0] bc, logic [14:0] bf, logic [31:0] w0,
                           logic [31:0] w1, logic [3:0] fx, logic [7:0] pr, logic [14:0] bd);
    write_register(CFG_LAYER_ENABLES, 32'(le));
    write_register(CFG_BLEND_CONTROL, 32'(bc));
    write_register(CFG_BLEND_FACTORS, 32'(bf));
    write_register(CFG_WINDOW0_BOUNDS, w0);
    write_register(CFG_WINDOW1_BOUNDS, w1);
    write_register(CFG_WIN_FX_ENABLES, 32'(fx));
    write_register(CFG_BG_PRIORITY, 32'(pr));
    write_register(CFG_BACKDROP_COLOR, 32'(bd));
    settings_count++;
  endtask

  // The first two settings are the extremes, the rest are random.
  task automatic phase_settings(int k);
    logic [6:0]  le;
    logic [13:0] bc;
    if (k == 0) begin
      write_all('1, '1, '1, '1, '1, '1, '1, '1);
    end else if (k == 1) begin
      write_all('0, '0, '0, '0, '0, '0, '0, '0);
    end else begin
      le = 7'($urandom);
      if ($urandom_range(2) != 0) le[3:0] = 4'hF;
      bc = 14'($urandom);
      if (bc[13:12] == MODE_OFF && $urandom_range(1) == 1) bc[13:12] = MODE_ALPHA;
      write_all(le, bc, 15'($urandom), random_window(), random_window(), 4'($urandom),
                8'($urandom), 15'($urandom));
    end
  endtask

  // Block until every queued pixel has come back, then let the pipeline settle.
  task automatic wait_for_idle();
    while (pending_pixels.size() != 0 || results_seen < pixels_issued) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic queue_random_pixels(int count);
    for (int n = 0; n < count; n++) pending_pixels.push_back(random_pixel());
  endtask

  // Input driver: presents queued pixels and records what each accepted beat should give.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_colors.push_back(composite_pixel(beat_on_wire));
        pixels_accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          beat_on_wire = pending_pixels.pop_front();
          pixels_issued++;
          in_ch.valid                   <= 1'b1;
          in_ch.pixel_x                 <= beat_on_wire.pixel_x;
          in_ch.line_y                  <= beat_on_wire.line_y;
          in_ch.bg0_pixel               <= beat_on_wire.bg_pixel[0];
          in_ch.bg1_pixel               <= beat_on_wire.bg_pixel[1];
          in_ch.bg2_pixel               <= beat_on_wire.bg_pixel[2];
          in_ch.bg3_pixel               <= beat_on_wire.bg_pixel[3];
          in_ch.sprite_pixel            <= beat_on_wire.sprite_pixel;
          in_ch.sprite_priority         <= beat_on_wire.sprite_priority;
          in_ch.sprite_semi_transparent <= beat_on_wire.semi_transparent;
          in_ch.in_object_window        <= beat_on_wire.object_window;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Output monitor: checks each color beat against the oldest outstanding pixel.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (expected_colors.size() == 0) begin
          if (mismatches < MAX_REPORTS)
            $display("unexpected color beat %h with no pixel outstanding", out_ch.final_color);
          mismatches++;
        end else begin
          oldest_color = expected_colors.pop_front();
          if (oldest_color != out_ch.final_color) begin
            if (mismatches < MAX_REPORTS)
              $display("color mismatch on result %0d: expected %h, got %h",
                       results_seen, oldest_color, out_ch.final_color);
            mismatches++;
          end
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Watchdog on the total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("run stopped by the watchdog after %0d cycles", cycle_count);
      $display("testbench: errors");
      $finish;
    end
  end

  // Stimulus sequencer.
  initial begin
    in_ch.valid                   = 1'b0;
    in_ch.pixel_x                 = '0;
    in_ch.line_y                  = '0;
    in_ch.bg0_pixel               = '0;
    in_ch.bg1_pixel               = '0;
    in_ch.bg2_pixel               = '0;
    in_ch.bg3_pixel               = '0;
    in_ch.sprite_pixel            = '0;
    in_ch.sprite_priority         = '0;
    in_ch.sprite_semi_transparent = 1'b0;
    in_ch.in_object_window        = 1'b0;
    out_ch.ready                  = 1'b0;
    cfg_we                        = 1'b0;
    cfg_index                     = '0;
    cfg_data                      = '0;
    reg_layer_enables             = '0;
    reg_blend_control             = '0;
    reg_blend_factors             = '0;
    reg_window0                   = '0;
    reg_window1                   = '0;
    reg_win_fx                    = '0;
    reg_bg_priority               = '0;
    reg_backdrop                  = '0;
    send_idle_pct                 = 0;
    recv_stall_pct                = 0;
    pixels_issued                 = 0;
    pixels_accepted               = 0;
    results_seen                  = 0;
    mismatches                    = 0;
    settings_count                = 0;
    cycle_count                   = 0;
    rst_n                         = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Registers at their reset values: no background is enabled, so only the sprite or the backdrop can show.
    pending_pixels.push_back(directed_pixel(8'd0, 8'd0, 16'h1234, 16'h7FFF, 2'd0, 1'b1, 1'b1));
    pending_pixels.push_back(directed_pixel(8'd255, 8'd255, 16'hFFFF, 16'hFFFF, 2'd3, 1'b0, 1'b0));
    wait_for_idle();

    // Alpha mode, both windows and the object window shown, mixed priorities.
    write_all(7'h7F, {MODE_ALPHA, 6'h3F, 6'h1F}, {5'd8, 5'd16, 5'd31}, 32'h140A_140A,
              32'hFF00_C80F, 4'b1010, 8'h17, 15'h1234);
    pending_pixels.push_back(directed_pixel(8'd0, 8'd0, 16'hFFFF, 16'h8000, 2'd0, 1'b0, 1'b0));
    pending_pixels.push_back(directed_pixel(8'd255, 8'd255, 16'h7FFF, 16'hFFFF, 2'd3, 1'b0, 1'b0));
    for (int p = 0; p < 4; p++)
      pending_pixels.push_back(directed_pixel(8'd100, 8'd50, 16'h0000, 16'h7FFF, 2'(p), 1'b0,
                                              1'b0));
    // Semi-transparent sprite over each slot.
    for (int p = 0; p < 4; p++)
      pending_pixels.push_back(directed_pixel(8'd100, 8'd50, 16'h3DEF, 16'h4210, 2'(p), 1'b1,
                                              1'b0));
    // On and just outside the window0 edges.
    pending_pixels.push_back(directed_pixel(8'd10, 8'd10, 16'h1111, 16'h8000, 2'd0, 1'b0, 1'b0));
    pending_pixels.push_back(directed_pixel(8'd20, 8'd20, 16'h1111, 16'h8000, 2'd0, 1'b0, 1'b0));
    pending_pixels.push_back(directed_pixel(8'd21, 8'd20, 16'h1111, 16'h8000, 2'd0, 1'b0, 1'b0));
    pending_pixels.push_back(directed_pixel(8'd9, 8'd9, 16'h1111, 16'h8000, 2'd0, 1'b0, 1'b0));
    // Outside both rectangles, with and without the object window.
    pending_pixels.push_back(directed_pixel(8'd250, 8'd5, 16'h2AAA, 16'h5555, 2'd2, 1'b1, 1'b1));
    pending_pixels.push_back(directed_pixel(8'd250, 8'd5, 16'h2AAA, 16'h5555, 2'd2, 1'b1, 1'b0));
    wait_for_idle();

    // Brighten mode with an empty window0.
    write_register(CFG_BLEND_CONTROL, 32'({MODE_WHITE, 6'h3F, 6'h3F}));
    write_register(CFG_WINDOW0_BOUNDS, 32'h140A_0A14);
    pending_pixels.push_back(directed_pixel(8'd15, 8'd15, 16'h7C1F, 16'h8000, 2'd0, 1'b0, 1'b0));
    pending_pixels.push_back(directed_pixel(8'd15, 8'd15, 16'h03E0, 16'h1234, 2'd1, 1'b1, 1'b0));
    wait_for_idle();

    // Darken mode with every factor past the clamp.
    write_register(CFG_BLEND_CONTROL, 32'({MODE_BLACK, 6'h3F, 6'h3F}));
    write_register(CFG_BLEND_FACTORS, 32'h0000_7FFF);
    pending_pixels.push_back(directed_pixel(8'd15, 8'd15, 16'h7C1F, 16'h8000, 2'd0, 1'b0, 1'b0));
    pending_pixels.push_back(directed_pixel(8'd15, 8'd15, 16'h03E0, 16'h1234, 2'd1, 1'b1, 1'b0));
    wait_for_idle();

    // Random phases, each with its own settings and flow-control pattern.
    for (int k = 0; k < NUM_PHASES; k++) begin
      phase_settings(k);
      case (k % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      queue_random_pixels(PHASE_PIXELS / 2);
      // Now and then hold the sender until the pipeline is empty mid-phase.
      if (k % 3 == 0) wait_for_idle();
      queue_random_pixels(PHASE_PIXELS - PHASE_PIXELS / 2);
      wait_for_idle();
    end

    if (expected_colors.size() != 0) begin
      $display("%0d pixels never produced a color", expected_colors.size());
      mismatches += expected_colors.size();
    end
    $display("covered %0d pixels under %0d register settings: all blend modes, windows,",
             pixels_accepted, settings_count);
    $display("sprite slots and four flow-control patterns; %0d failures", mismatches);
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
